>>> design/xalu_pkg.sv
`timescale 1ns / 1ps

package xalu_pkg;

    // Operation codes
    localparam logic [4:0] K_ADD  = 5'd0;
    localparam logic [4:0] K_ADC  = 5'd1;
    localparam logic [4:0] K_SUB  = 5'd2;
    localparam logic [4:0] K_SBB  = 5'd3;
    localparam logic [4:0] K_AND  = 5'd4;
    localparam logic [4:0] K_OR   = 5'd5;
    localparam logic [4:0] K_XOR  = 5'd6;
    localparam logic [4:0] K_SHL  = 5'd7;
    localparam logic [4:0] K_SHR  = 5'd8;
    localparam logic [4:0] K_SAR  = 5'd9;
    localparam logic [4:0] K_MUL  = 5'd10;
    localparam logic [4:0] K_IMUL = 5'd11;
    localparam logic [4:0] K_DIV  = 5'd12;
    localparam logic [4:0] K_IDIV = 5'd13;
    localparam logic [4:0] K_MOD  = 5'd14;
    localparam logic [4:0] K_IMOD = 5'd15;
    localparam logic [4:0] K_SAL  = 5'd16;

    // Size codes
    localparam logic [1:0] SZ_8  = 2'd0;
    localparam logic [1:0] SZ_16 = 2'd1;
    localparam logic [1:0] SZ_32 = 2'd2;

    // Request to the multiply/divide unit
    typedef struct packed {
        logic       start;
        logic       is_div;
        logic       is_signed;
        logic       want_rem;
        logic [1:0] sc;
    } md_req_t;

    // Response from the multiply/divide unit
    typedef struct packed {
        logic        done;
        logic [63:0] value;
        logic        ovf;
    } md_rsp_t;

    function automatic logic [31:0] mask_n(input logic [1:0] sc);
        logic [31:0] m;
        case (sc)
            SZ_8:    m = 32'h0000_00FF;
            SZ_16:   m = 32'h0000_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [63:0] mask_2n(input logic [1:0] sc);
        logic [63:0] m;
        case (sc)
            SZ_8:    m = 64'h0000_0000_0000_FFFF;
            SZ_16:   m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic msb_n(input logic [31:0] v, input logic [1:0] sc);
        logic b;
        case (sc)
            SZ_8:    b = v[7];
            SZ_16:   b = v[15];
            default: b = v[31];
        endcase
        return b;
    endfunction

    // Sign-extend the low n bits to 32
    function automatic logic [31:0] sext_n(input logic [31:0] v, input logic [1:0] sc);
        logic [31:0] r;
        case (sc)
            SZ_8:    r = {{24{v[7]}}, v[7:0]};
            SZ_16:   r = {{16{v[15]}}, v[15:0]};
            default: r = v;
        endcase
        return r;
    endfunction

    // Sign-extend the low n bits to 64
    function automatic logic [63:0] sext_n64(input logic [63:0] v, input logic [1:0] sc);
        logic [63:0] r;
        case (sc)
            SZ_8:    r = {{56{v[7]}}, v[7:0]};
            SZ_16:   r = {{48{v[15]}}, v[15:0]};
            default: r = {{32{v[31]}}, v[31:0]};
        endcase
        return r;
    endfunction

    // Sign-extend the low 2n bits to 64
    function automatic logic [63:0] sext_2n(input logic [63:0] v, input logic [1:0] sc);
        logic [63:0] r;
        case (sc)
            SZ_8:    r = {{48{v[15]}}, v[15:0]};
            SZ_16:   r = {{32{v[31]}}, v[31:0]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

>>> design/xalu_if.sv
`timescale 1ns / 1ps

// Operation channel
interface xalu_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  kind;
    logic [63:0] source_operand;
    logic [63:0] destination_operand;
    logic [1:0]  size_code;

    modport source (output valid, kind, source_operand, destination_operand, size_code,
                    input ready);
    modport sink   (input valid, kind, source_operand, destination_operand, size_code,
                    output ready);
endinterface

// Result channel
interface xalu_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic        carry_out;
    logic        parity_out;
    logic        zero_out;
    logic        sign_out;
    logic        overflow_out;
    logic        divide_error;

    modport source (output valid, value, carry_out, parity_out, zero_out, sign_out,
                    overflow_out, divide_error, input ready);
    modport sink   (input valid, value, carry_out, parity_out, zero_out, sign_out,
                    overflow_out, divide_error, output ready);
endinterface

>>> design/xalu_muldiv.sv
`timescale 1ns / 1ps

// Bit-serial multiply (shift-add, 32 steps) and divide (restoring, 64 steps).
// Signed forms run on magnitudes and fix the sign at the end.
module xalu_muldiv
    import xalu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  md_req_t     req,
    input  logic [63:0] src,
    input  logic [63:0] dst,
    output md_rsp_t     rsp
);

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_RUN  = 4'b0010,
        M_FIX  = 4'b0100,
        M_DONE = 4'b1000
    } md_state_t;

    md_state_t   state_reg, state_next;
    logic [31:0] hi_reg, hi_next;
    logic [63:0] lo_reg, lo_next;
    logic [31:0] opnd_reg, opnd_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        is_div_reg, is_div_next;
    logic        signed_reg, signed_next;
    logic        rem_reg, rem_next;
    logic [1:0]  sc_reg, sc_next;

    // Operand preparation at start
    logic [31:0] m32, a32, b32, ma32, mb32;
    logic        an, bn, dn;
    logic [63:0] dvd64, mdvd;

    always_comb
    begin
        m32   = mask_n(req.sc);
        a32   = req.is_signed ? sext_n(dst[31:0] & m32, req.sc) : (dst[31:0] & m32);
        b32   = req.is_signed ? sext_n(src[31:0] & m32, req.sc) : (src[31:0] & m32);
        an    = req.is_signed & a32[31];
        bn    = req.is_signed & b32[31];
        ma32  = an ? (32'd0 - a32) : a32;
        mb32  = bn ? (32'd0 - b32) : b32;
        dvd64 = req.is_signed ? sext_2n(dst, req.sc) : (dst & mask_2n(req.sc));
        dn    = req.is_signed & dvd64[63];
        mdvd  = dn ? (64'd0 - dvd64) : dvd64;
    end

    // One step of the serial datapath
    logic [32:0] sum33, t33;
    logic        ge;
    logic [63:0] pre;

    always_comb
    begin
        sum33 = {1'b0, hi_reg} + {1'b0, (lo_reg[0] ? opnd_reg : 32'd0)};
        t33   = {hi_reg, lo_reg[63]};
        ge    = (t33 >= {1'b0, opnd_reg});
        if (is_div_reg)
            pre = rem_reg ? {32'd0, hi_reg} : lo_reg;
        else
            pre = {hi_reg, lo_reg[31:0]};
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        opnd_next   = opnd_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        is_div_next = is_div_reg;
        signed_next = signed_reg;
        rem_next    = rem_reg;
        sc_next     = sc_reg;
        case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    is_div_next = req.is_div;
                    signed_next = req.is_signed;
                    rem_next    = req.want_rem;
                    sc_next     = req.sc;
                    hi_next     = 32'd0;
                    state_next  = M_RUN;
                    if (req.is_div)
                    begin
                        lo_next   = mdvd;
                        opnd_next = mb32;
                        cnt_next  = 6'd63;
                        neg_next  = req.want_rem ? dn : (dn ^ bn);
                    end
                    else
                    begin
                        lo_next   = {32'd0, mb32};
                        opnd_next = ma32;
                        cnt_next  = 6'd31;
                        neg_next  = an ^ bn;
                    end
                end
            end
            M_RUN:
            begin
                if (is_div_reg)
                begin
                    hi_next = ge ? (t33[31:0] - opnd_reg) : t33[31:0];
                    lo_next = {lo_reg[62:0], ge};
                end
                else
                begin
                    hi_next = sum33[32:1];
                    lo_next = {lo_reg[63:32], sum33[0], lo_reg[31:1]};
                end
                if (cnt_reg == 6'd0)
                    state_next = M_FIX;
                else
                    cnt_next = cnt_reg - 6'd1;
            end
            M_FIX:
            begin
                lo_next    = neg_reg ? (64'd0 - pre) : pre;
                state_next = M_DONE;
            end
            M_DONE:
            begin
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    // Response
    always_comb
    begin
        rsp.done = (state_reg == M_DONE);
        if (is_div_reg)
            rsp.value = lo_reg & {32'd0, mask_n(sc_reg)};
        else if (signed_reg)
            rsp.value = lo_reg & mask_2n(sc_reg);
        else
            rsp.value = lo_reg;
        if (signed_reg)
            rsp.ovf = (sext_n64(lo_reg, sc_reg) != lo_reg);
        else
            rsp.ovf = ((lo_reg & ~{32'd0, mask_n(sc_reg)}) != 64'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= M_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        opnd_reg   <= opnd_next;
        cnt_reg    <= cnt_next;
        neg_reg    <= neg_next;
        is_div_reg <= is_div_next;
        signed_reg <= signed_next;
        rem_reg    <= rem_next;
        sc_reg     <= sc_next;
    end

endmodule

>>> design/x86_integer_alu_with_flags_core.sv
`timescale 1ns / 1ps

// x86 integer ALU with stored flags (CF, PF, ZF, SF, OF).
// Channels: req carries one operation beat (kind, operands, size code);
// res returns one beat per operation with the value, the flags as they stand
// after it, and divide_error. Both use valid/ready.
// Execution path after accept:
//   add/adc/sub/sbb/logic, zero shift count, zero divisor, unused kind: on the incoming beat
//   shifts: one bit per cycle through the shift register
//   mul/imul: 32 shift-add steps in the serial multiply unit
//   div/idiv/mod/imod: 64 restoring steps in the serial divide unit
// One operation executes at a time; req.ready is high only while the block is
// idle, so a new beat is taken once the last result has left the hold state.
// A finished result waits in the output register; while res is stalled a new
// operation may be accepted and executed, and its result holds until the
// output register frees up.
// Reset clears all flags and drops res.valid.
module x86_integer_alu_with_flags_core
    import xalu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    xalu_in_if.sink   req,
    xalu_out_if.source res
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SHIFT = 4'b0010,
        S_MD    = 4'b0100,
        S_HOLD  = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic        carry_flag_reg, carry_flag_next;
    logic        parity_flag_reg, parity_flag_next;
    logic        zero_flag_reg, zero_flag_next;
    logic        sign_flag_reg, sign_flag_next;
    logic        overflow_flag_reg, overflow_flag_next;
    logic [4:0]  kind_reg, kind_next;
    logic [1:0]  sc_reg, sc_next;
    logic [63:0] pend_val_reg, pend_val_next;
    logic        pend_derr_reg, pend_derr_next;
    logic [31:0] sh_reg, sh_next;
    logic [4:0]  sh_cnt_reg, sh_cnt_next;
    logic        sh_cf_reg, sh_cf_next;
    logic        sh_one_reg, sh_one_next;
    logic        sh_msb_reg, sh_msb_next;
    logic        res_valid_reg, res_valid_next;
    logic [63:0] out_val_reg;
    logic        out_cf_reg, out_pf_reg, out_zf_reg, out_sf_reg, out_of_reg, out_derr_reg;

    md_req_t     md_req;
    md_rsp_t     md_rsp;
    logic        out_load;

    xalu_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .src   (req.source_operand),
        .dst   (req.destination_operand),
        .rsp   (md_rsp)
    );

    // Combinational add, subtract and logic on the incoming beat
    logic [31:0] m32, d32, s32, add_val, sub_val;
    logic [32:0] sum33, diff33;
    logic        cin, add_cf, add_of, sub_of;
    logic [4:0]  cnt5;

    always_comb
    begin
        m32     = mask_n(req.size_code);
        d32     = req.destination_operand[31:0] & m32;
        s32     = req.source_operand[31:0] & m32;
        cnt5    = req.source_operand[4:0];
        cin     = (req.kind == K_ADC || req.kind == K_SBB) ? carry_flag_reg : 1'b0;
        sum33   = {1'b0, d32} + {1'b0, s32} + {32'd0, cin};
        diff33  = {1'b0, d32} - {1'b0, s32} - {32'd0, cin};
        add_val = sum33[31:0] & m32;
        sub_val = diff33[31:0] & m32;
        case (req.size_code)
            SZ_8:    add_cf = sum33[8];
            SZ_16:   add_cf = sum33[16];
            default: add_cf = sum33[32];
        endcase
        add_of = msb_n(~(d32 ^ s32) & (d32 ^ add_val), req.size_code);
        sub_of = msb_n((d32 ^ s32) & (d32 ^ sub_val), req.size_code);
    end

    // One shift step on the serial register
    logic [31:0] sm32, sh_step;
    logic        sh_out;

    always_comb
    begin
        sm32 = mask_n(sc_reg);
        if (kind_reg == K_SHR)
        begin
            sh_out  = sh_reg[0];
            sh_step = sh_reg >> 1;
        end
        else if (kind_reg == K_SAR)
        begin
            sh_out  = sh_reg[0];
            sh_step = (sh_reg >> 1) |
                      (msb_n(sh_reg, sc_reg) ? (sm32 & ~(sm32 >> 1)) : 32'd0);
        end
        else
        begin
            sh_out  = msb_n(sh_reg, sc_reg);
            sh_step = (sh_reg << 1) & sm32;
        end
    end

    assign out_load = (state_reg == S_HOLD) && (!res_valid_reg || res.ready);

    // Control and flag update
    logic        upd_pzs;
    logic [31:0] pzs_val;
    logic [1:0]  pzs_sc;

    always_comb
    begin
        state_next         = state_reg;
        carry_flag_next    = carry_flag_reg;
        parity_flag_next   = parity_flag_reg;
        zero_flag_next     = zero_flag_reg;
        sign_flag_next     = sign_flag_reg;
        overflow_flag_next = overflow_flag_reg;
        kind_next          = kind_reg;
        sc_next            = sc_reg;
        pend_val_next      = pend_val_reg;
        pend_derr_next     = pend_derr_reg;
        sh_next            = sh_reg;
        sh_cnt_next        = sh_cnt_reg;
        sh_cf_next         = sh_cf_reg;
        sh_one_next        = sh_one_reg;
        sh_msb_next        = sh_msb_reg;
        upd_pzs            = 1'b0;
        pzs_val            = 32'd0;
        pzs_sc             = sc_reg;
        md_req.start       = 1'b0;
        md_req.is_div      = (req.kind inside {K_DIV, K_IDIV, K_MOD, K_IMOD});
        md_req.is_signed   = (req.kind inside {K_IMUL, K_IDIV, K_IMOD});
        md_req.want_rem    = (req.kind inside {K_MOD, K_IMOD});
        md_req.sc          = req.size_code;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next      = req.kind;
                    sc_next        = req.size_code;
                    pend_val_next  = 64'd0;
                    pend_derr_next = 1'b0;
                    pzs_sc         = req.size_code;
                    state_next     = S_HOLD;
                    case (req.kind)
                        K_ADD, K_ADC:
                        begin
                            pend_val_next      = {32'd0, add_val};
                            carry_flag_next    = add_cf;
                            overflow_flag_next = add_of;
                            upd_pzs            = 1'b1;
                            pzs_val            = add_val;
                        end
                        K_SUB, K_SBB:
                        begin
                            pend_val_next      = {32'd0, sub_val};
                            carry_flag_next    = diff33[32];
                            overflow_flag_next = sub_of;
                            upd_pzs            = 1'b1;
                            pzs_val            = sub_val;
                        end
                        K_AND, K_OR, K_XOR:
                        begin
                            if (req.kind == K_AND)
                                pzs_val = d32 & s32;
                            else if (req.kind == K_OR)
                                pzs_val = d32 | s32;
                            else
                                pzs_val = d32 ^ s32;
                            pend_val_next      = {32'd0, pzs_val};
                            carry_flag_next    = 1'b0;
                            overflow_flag_next = 1'b0;
                            upd_pzs            = 1'b1;
                        end
                        K_SHL, K_SAL, K_SHR, K_SAR:
                        begin
                            if (cnt5 == 5'd0)
                                pend_val_next = {32'd0, d32};
                            else
                            begin
                                sh_next     = d32;
                                sh_cnt_next = cnt5;
                                sh_cf_next  = 1'b0;
                                sh_one_next = (cnt5 == 5'd1);
                                sh_msb_next = msb_n(d32, req.size_code);
                                state_next  = S_SHIFT;
                            end
                        end
                        K_MUL, K_IMUL:
                        begin
                            md_req.start = 1'b1;
                            state_next   = S_MD;
                        end
                        K_DIV, K_IDIV, K_MOD, K_IMOD:
                        begin
                            if (s32 == 32'd0)
                                pend_derr_next = 1'b1;
                            else
                            begin
                                md_req.start = 1'b1;
                                state_next   = S_MD;
                            end
                        end
                        default:
                        begin
                            pend_val_next = 64'd0;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                if (sh_cnt_reg != 5'd0)
                begin
                    sh_next     = sh_step;
                    sh_cf_next  = sh_out;
                    sh_cnt_next = sh_cnt_reg - 5'd1;
                end
                else
                begin
                    pend_val_next   = {32'd0, sh_reg};
                    carry_flag_next = sh_cf_reg;
                    if (sh_one_reg)
                    begin
                        if (kind_reg == K_SHR)
                            overflow_flag_next = sh_msb_reg;
                        else if (kind_reg == K_SAR)
                            overflow_flag_next = 1'b0;
                        else
                            overflow_flag_next = msb_n(sh_reg, sc_reg) ^ sh_cf_reg;
                    end
                    upd_pzs    = 1'b1;
                    pzs_val    = sh_reg;
                    state_next = S_HOLD;
                end
            end
            S_MD:
            begin
                if (md_rsp.done)
                begin
                    pend_val_next = md_rsp.value;
                    if (kind_reg == K_MUL || kind_reg == K_IMUL)
                    begin
                        carry_flag_next    = md_rsp.ovf;
                        overflow_flag_next = md_rsp.ovf;
                    end
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Parity, zero and sign from the sized result
        if (upd_pzs)
        begin
            parity_flag_next = ~^pzs_val[7:0];
            zero_flag_next   = ((pzs_val & mask_n(pzs_sc)) == 32'd0);
            sign_flag_next   = msb_n(pzs_val, pzs_sc);
        end
    end

    // Output register handshake
    always_comb
    begin
        res_valid_next = res_valid_reg & ~res.ready;
        if (out_load)
            res_valid_next = 1'b1;
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign res.valid        = res_valid_reg;
    assign res.value        = out_val_reg;
    assign res.carry_out    = out_cf_reg;
    assign res.parity_out   = out_pf_reg;
    assign res.zero_out     = out_zf_reg;
    assign res.sign_out     = out_sf_reg;
    assign res.overflow_out = out_of_reg;
    assign res.divide_error = out_derr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            carry_flag_reg    <= 1'b0;
            parity_flag_reg   <= 1'b0;
            zero_flag_reg     <= 1'b0;
            sign_flag_reg     <= 1'b0;
            overflow_flag_reg <= 1'b0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            carry_flag_reg    <= carry_flag_next;
            parity_flag_reg   <= parity_flag_next;
            zero_flag_reg     <= zero_flag_next;
            sign_flag_reg     <= sign_flag_next;
            overflow_flag_reg <= overflow_flag_next;
            res_valid_reg     <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        sc_reg        <= sc_next;
        pend_val_reg  <= pend_val_next;
        pend_derr_reg <= pend_derr_next;
        sh_reg        <= sh_next;
        sh_cnt_reg    <= sh_cnt_next;
        sh_cf_reg     <= sh_cf_next;
        sh_one_reg    <= sh_one_next;
        sh_msb_reg    <= sh_msb_next;
        if (out_load)
        begin
            out_val_reg  <= pend_val_reg;
            out_cf_reg   <= carry_flag_reg;
            out_pf_reg   <= parity_flag_reg;
            out_zf_reg   <= zero_flag_reg;
            out_sf_reg   <= sign_flag_reg;
            out_of_reg   <= overflow_flag_reg;
            out_derr_reg <= pend_derr_reg;
        end
    end

    // A result beat appears only from the hold state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == S_HOLD))
        else $error("result valid rose outside hold state");

    // A divide error always carries a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.divide_error) |-> (res.value == 64'd0))
        else $error("divide error with nonzero value");

    // The serial unit finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        md_rsp.done |-> (state_reg == S_MD))
        else $error("multiply/divide done while not waiting");

endmodule
